// ----- src/particle_to_grid_face_average_macros.svh -----
// assertion macros shared by the particle-to-grid face average rtl
`ifndef PARTICLE_TO_GRID_FACE_AVERAGE_MACROS_SVH
`define PARTICLE_TO_GRID_FACE_AVERAGE_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define P2G_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("p2g same-cycle check failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define P2G_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("p2g next-cycle check failed");

`endif

// ----- src/p2g_pkg.sv -----
// shared constants, types and codes of the particle-to-grid face average block
`default_nettype none
package p2g_pkg;

	localparam int MAX_COLS      = 64;
	localparam int MAX_ROWS      = 64;
	localparam int POS_FRAC_BITS = 8;

	localparam int XFACES  = (MAX_COLS + 1) * MAX_ROWS;
	localparam int YFACES  = MAX_COLS * (MAX_ROWS + 1);
	localparam int FACES   = (XFACES > YFACES) ? XFACES : YFACES;
	localparam int ADDR_W  = $clog2(FACES);

	localparam int SIZE_W  = 7;
	localparam int POS_W   = 16;
	localparam int VEL_W   = 16;
	localparam int AVG_W   = 16;
	localparam int SUM_W   = 28;
	localparam int CNT_W   = 12;
	localparam int REQ_W   = 2;
	localparam int CRAW_W  = POS_W - 1 - POS_FRAC_BITS;
	localparam int CMP_W   = (CRAW_W > SIZE_W) ? CRAW_W : SIZE_W;
	localparam int CTR_W   = SIZE_W + POS_FRAC_BITS + 1;

	localparam int IN_FIELDS_W = 2 * POS_W + 2 * VEL_W + 1 + 2 * SIZE_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((AVG_W + CNT_W + 7) / 8) * 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [REQ_W-1:0] REQ_DEPOSIT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

	localparam logic CFG_GRID_COLS = 1'b0;
	localparam logic CFG_GRID_ROWS = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0]        count;
		logic signed [SUM_W-1:0] sum;
	} face_t;

	localparam int FACE_W = $bits(face_t);

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ----- src/p2g_ram.sv -----
// generic single-port ram with registered read
`default_nettype none
module p2g_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- src/p2g_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module p2g_div (
	input  logic               clk,
	input  logic               arst_n,
	input  p2g_pkg::div_req_t  req,
	output p2g_pkg::div_rsp_t  rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [p2g_pkg::DIV_CNT_W-1:0] step_q;
	logic [p2g_pkg::CNT_W-1:0]     rem_q;
	logic [p2g_pkg::SUM_W-1:0]     quo_q;
	logic [p2g_pkg::CNT_W-1:0]     dvs_q;

	logic [p2g_pkg::CNT_W:0]       shifted;
	logic [p2g_pkg::CNT_W+1:0]     trial;
	logic                          fits;

	// shift next dividend bit into the remainder and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[p2g_pkg::SUM_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		fits    = !trial[p2g_pkg::CNT_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == p2g_pkg::DIV_CNT_W'(p2g_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[p2g_pkg::CNT_W-1:0] : shifted[p2g_pkg::CNT_W-1:0];
			quo_q <= {quo_q[p2g_pkg::SUM_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

// ----- src/particle_to_grid_face_average.sv -----
// particle-to-grid nearest-face deposit, face average read and clear; top level
// Items are handled one at a time. A deposit runs through decode, a read of the x-face
// and y-face rams, and a write-back of both updated entries. A face read skips the divider
// when the face is outside the grid or empty, and otherwise waits for the 28-step divider
// that forms sum / count. A clear sweeps both face rams one entry a cycle. After reset the
// same clearing pass over all 4160 entries runs before the first item is accepted;
// configuration writes are taken at any time. A finished result sits in an output register
// until taken, and the next item is accepted once it has been loaded.
`default_nettype none
`include "particle_to_grid_face_average_macros.svh"
module particle_to_grid_face_average (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [p2g_pkg::SIZE_W-1:0]         cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// pos_x, pos_y, vel_x, vel_y, face_axis, face_col, face_row, zero pad
	input  logic [p2g_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// req_type
	input  logic [p2g_pkg::REQ_W-1:0]          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// avg_velocity, contribution_count, zero pad
	output logic [p2g_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECODE  = 3'd1;
	localparam logic [2:0] ST_FETCH   = 3'd2;
	localparam logic [2:0] ST_DEP_WR  = 3'd3;
	localparam logic [2:0] ST_RD_DATA = 3'd4;
	localparam logic [2:0] ST_DIV     = 3'd5;
	localparam logic [2:0] ST_CLEAR   = 3'd6;
	localparam logic [2:0] ST_RESULT  = 3'd7;

	localparam int SIZE_W = p2g_pkg::SIZE_W;
	localparam int ADDR_W = p2g_pkg::ADDR_W;
	localparam int POS_W  = p2g_pkg::POS_W;
	localparam int VEL_W  = p2g_pkg::VEL_W;
	localparam int SUM_W  = p2g_pkg::SUM_W;
	localparam int CNT_W  = p2g_pkg::CNT_W;
	localparam int AVG_W  = p2g_pkg::AVG_W;
	localparam int CMP_W  = p2g_pkg::CMP_W;
	localparam int CTR_W  = p2g_pkg::CTR_W;
	localparam int FRAC   = p2g_pkg::POS_FRAC_BITS;

	// cell by truncation, clamped to the grid in use
	function automatic logic [SIZE_W-1:0] cell_of(input logic [POS_W-1:0] pos,
			input logic [SIZE_W-1:0] n);
		logic [CMP_W-1:0] raw;
		logic [CMP_W-1:0] last;
		raw  = CMP_W'(pos[POS_W-2:FRAC]);
		last = CMP_W'(n - SIZE_W'(1));
		if (pos[POS_W-1]) begin
			cell_of = '0;
		end else if (raw > last) begin
			cell_of = SIZE_W'(last);
		end else begin
			cell_of = SIZE_W'(raw);
		end
	endfunction

	// nearest face: the cell's own face when before its center, else the next one
	function automatic logic [SIZE_W-1:0] face_of(input logic [POS_W-1:0] pos,
			input logic [SIZE_W-1:0] base_cell);
		logic [CTR_W-1:0] ctr;
		ctr = (CTR_W'(base_cell) << FRAC) + CTR_W'(1 << (FRAC - 1));
		if ($signed(pos) < $signed(ctr)) begin
			face_of = base_cell;
		end else begin
			face_of = base_cell + SIZE_W'(1);
		end
	endfunction

	logic [2:0]               state_q;
	logic [SIZE_W-1:0]        grid_cols_q;
	logic [SIZE_W-1:0]        grid_rows_q;
	logic [ADDR_W-1:0]        clr_addr_q;
	logic                     post_q;

	logic [p2g_pkg::REQ_W-1:0] req_q;
	logic [POS_W-1:0]         pos_x_q;
	logic [POS_W-1:0]         pos_y_q;
	logic signed [VEL_W-1:0]  vel_x_q;
	logic signed [VEL_W-1:0]  vel_y_q;
	logic                     axis_q;
	logic [SIZE_W-1:0]        col_q;
	logic [SIZE_W-1:0]        row_q;

	logic [ADDR_W-1:0]        addr_x_q;
	logic [ADDR_W-1:0]        addr_y_q;
	logic                     ok_q;
	logic                     neg_q;
	logic [AVG_W-1:0]         res_avg_q;
	logic [CNT_W-1:0]         res_cnt_q;
	logic                     m_valid_q;
	logic [p2g_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic [SIZE_W-1:0]        cols_eff;
	logic [SIZE_W-1:0]        rows_eff;
	logic [SIZE_W-1:0]        cell_x;
	logic [SIZE_W-1:0]        cell_y;
	logic [SIZE_W-1:0]        face_x;
	logic [SIZE_W-1:0]        face_y;
	logic [ADDR_W-1:0]        dep_addr_x;
	logic [ADDR_W-1:0]        dep_addr_y;
	logic                     rd_ok_x;
	logic                     rd_ok_y;
	logic [ADDR_W-1:0]        rd_addr_x;
	logic [ADDR_W-1:0]        rd_addr_y;

	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_addr_x;
	logic [ADDR_W-1:0]        ram_addr_y;
	p2g_pkg::face_t           ram_wdata_x;
	p2g_pkg::face_t           ram_wdata_y;
	p2g_pkg::face_t           ram_rdata_x;
	p2g_pkg::face_t           ram_rdata_y;
	p2g_pkg::face_t           upd_x;
	p2g_pkg::face_t           upd_y;
	p2g_pkg::face_t           sel_face;
	logic [SUM_W-1:0]         sum_mag;
	logic [SUM_W-1:0]         quo_signed;
	logic                     out_free;
	logic                     s_accept;

	p2g_pkg::div_req_t        div_req;
	p2g_pkg::div_rsp_t        div_rsp;

	// grid size in use: zero counts as one, oversize is clamped
	always_comb begin
		if (grid_cols_q == '0) begin
			cols_eff = SIZE_W'(1);
		end else if (grid_cols_q > SIZE_W'(p2g_pkg::MAX_COLS)) begin
			cols_eff = SIZE_W'(p2g_pkg::MAX_COLS);
		end else begin
			cols_eff = grid_cols_q;
		end
		if (grid_rows_q == '0) begin
			rows_eff = SIZE_W'(1);
		end else if (grid_rows_q > SIZE_W'(p2g_pkg::MAX_ROWS)) begin
			rows_eff = SIZE_W'(p2g_pkg::MAX_ROWS);
		end else begin
			rows_eff = grid_rows_q;
		end
	end

	always_comb begin
		cell_x     = cell_of(pos_x_q, cols_eff);
		cell_y     = cell_of(pos_y_q, rows_eff);
		face_x     = face_of(pos_x_q, cell_x);
		face_y     = face_of(pos_y_q, cell_y);
		dep_addr_x = ADDR_W'(cell_y) * ADDR_W'(p2g_pkg::MAX_COLS + 1) + ADDR_W'(face_x);
		dep_addr_y = ADDR_W'(face_y) * ADDR_W'(p2g_pkg::MAX_COLS) + ADDR_W'(cell_x);
		rd_ok_x    = (col_q <= cols_eff) && (row_q < rows_eff);
		rd_ok_y    = (col_q < cols_eff) && (row_q <= rows_eff);
		// out-of-grid reads park on entry 0 so the address stays inside the ram
		rd_addr_x  = rd_ok_x ?
			ADDR_W'(row_q) * ADDR_W'(p2g_pkg::MAX_COLS + 1) + ADDR_W'(col_q) : '0;
		rd_addr_y  = rd_ok_y ?
			ADDR_W'(row_q) * ADDR_W'(p2g_pkg::MAX_COLS) + ADDR_W'(col_q) : '0;
	end

	// saturated faces write back unchanged
	always_comb begin
		upd_x = ram_rdata_x;
		upd_y = ram_rdata_y;
		if (ram_rdata_x.count != p2g_pkg::COUNT_MAX) begin
			upd_x.sum   = ram_rdata_x.sum + SUM_W'(vel_x_q);
			upd_x.count = ram_rdata_x.count + CNT_W'(1);
		end
		if (ram_rdata_y.count != p2g_pkg::COUNT_MAX) begin
			upd_y.sum   = ram_rdata_y.sum + SUM_W'(vel_y_q);
			upd_y.count = ram_rdata_y.count + CNT_W'(1);
		end
	end

	always_comb begin
		ram_we      = (state_q == ST_CLEAR) || (state_q == ST_DEP_WR);
		ram_addr_x  = (state_q == ST_CLEAR) ? clr_addr_q : addr_x_q;
		ram_addr_y  = (state_q == ST_CLEAR) ? clr_addr_q : addr_y_q;
		ram_wdata_x = (state_q == ST_CLEAR) ? '0 : upd_x;
		ram_wdata_y = (state_q == ST_CLEAR) ? '0 : upd_y;
	end

	always_comb begin
		sel_face         = axis_q ? ram_rdata_y : ram_rdata_x;
		sum_mag          = sel_face.sum[SUM_W-1] ? SUM_W'(-sel_face.sum) : SUM_W'(sel_face.sum);
		div_req.start    = (state_q == ST_RD_DATA) && ok_q && (sel_face.count != '0);
		div_req.dividend = sum_mag;
		div_req.divisor  = sel_face.count;
		quo_signed       = neg_q ? (~div_rsp.quotient + SUM_W'(1)) : div_rsp.quotient;
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= SIZE_W'(p2g_pkg::MAX_COLS);
			grid_rows_q <= SIZE_W'(p2g_pkg::MAX_ROWS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				p2g_pkg::CFG_GRID_COLS: grid_cols_q <= cfg_wdata;
				p2g_pkg::CFG_GRID_ROWS: grid_rows_q <= cfg_wdata;
			endcase
		end
	end

	// output valid: loaded from the result state, dropped once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// sequencer; reset starts with a clearing pass that posts no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			post_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					unique case (req_q)
						p2g_pkg::REQ_DEPOSIT: state_q <= ST_FETCH;
						p2g_pkg::REQ_READ:    state_q <= ST_FETCH;
						p2g_pkg::REQ_CLEAR: begin
							state_q    <= ST_CLEAR;
							clr_addr_q <= '0;
							post_q     <= 1'b1;
						end
						default: state_q <= ST_RESULT;
					endcase
				end
				ST_FETCH: begin
					state_q <= (req_q == p2g_pkg::REQ_DEPOSIT) ? ST_DEP_WR : ST_RD_DATA;
				end
				ST_DEP_WR: begin
					state_q <= ST_RESULT;
				end
				ST_RD_DATA: begin
					state_q <= div_req.start ? ST_DIV : ST_RESULT;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(p2g_pkg::FACES - 1)) begin
						state_q <= post_q ? ST_RESULT : ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_q   <= s_axis_tuser;
			pos_x_q <= s_axis_tdata[POS_W-1:0];
			pos_y_q <= s_axis_tdata[2*POS_W-1:POS_W];
			vel_x_q <= s_axis_tdata[2*POS_W+VEL_W-1:2*POS_W];
			vel_y_q <= s_axis_tdata[2*POS_W+2*VEL_W-1:2*POS_W+VEL_W];
			axis_q  <= s_axis_tdata[2*POS_W+2*VEL_W];
			col_q   <= s_axis_tdata[2*POS_W+2*VEL_W+SIZE_W:2*POS_W+2*VEL_W+1];
			row_q   <= s_axis_tdata[2*POS_W+2*VEL_W+2*SIZE_W:2*POS_W+2*VEL_W+SIZE_W+1];
		end
		if (state_q == ST_DECODE) begin
			res_avg_q <= '0;
			res_cnt_q <= '0;
			if (req_q == p2g_pkg::REQ_DEPOSIT) begin
				addr_x_q <= dep_addr_x;
				addr_y_q <= dep_addr_y;
			end else begin
				addr_x_q <= rd_addr_x;
				addr_y_q <= rd_addr_y;
			end
			ok_q <= axis_q ? rd_ok_y : rd_ok_x;
		end
		if ((state_q == ST_RD_DATA) && ok_q) begin
			res_cnt_q <= sel_face.count;
			neg_q     <= sel_face.sum[SUM_W-1];
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			res_avg_q <= quo_signed[AVG_W-1:0];
		end
		if ((state_q == ST_RESULT) && out_free) begin
			m_tdata_q <= p2g_pkg::OUT_DATA_W'({res_cnt_q, res_avg_q});
		end
	end

	p2g_ram #(
		.WIDTH (p2g_pkg::FACE_W),
		.DEPTH (p2g_pkg::FACES)
	) u_xface_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr_x),
		.wdata (ram_wdata_x),
		.rdata (ram_rdata_x)
	);

	p2g_ram #(
		.WIDTH (p2g_pkg::FACE_W),
		.DEPTH (p2g_pkg::FACES)
	) u_yface_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr_y),
		.wdata (ram_wdata_y),
		.rdata (ram_rdata_y)
	);

	p2g_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	`P2G_ASSERT_NEXT(a_accept_decodes, s_accept, state_q == ST_DECODE)
	`P2G_ASSERT_IMPL(a_div_done_in_div, div_rsp.done, state_q == ST_DIV)
	`P2G_ASSERT_NEXT(a_div_starts, div_req.start, div_rsp.busy && (state_q == ST_DIV))
	`P2G_ASSERT_NEXT(a_result_posts, (state_q == ST_RESULT) && out_free, m_axis_tvalid && (state_q == ST_IDLE))
	`P2G_ASSERT_IMPL(a_fetch_after_decode, state_q == ST_FETCH, $past(state_q) == ST_DECODE)

endmodule
`default_nettype wire
